// ----- hw/rtl/multichannel_biquad_shelf_filter_assert.svh -----
// Assertion macros for the multichannel biquad shelf filter.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef MULTICHANNEL_BIQUAD_SHELF_FILTER_ASSERT_SVH
`define MULTICHANNEL_BIQUAD_SHELF_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define MBSF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define MBSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`define MBSF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define MBSF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MBSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define MBSF_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- hw/rtl/mbsf_pkg.sv -----
// Types and constants for the multichannel biquad shelf filter.
// No dependencies.
package mbsf_pkg;

	localparam int CH_BITS        = 4;
	localparam int NUM_CHANNELS   = 1 << CH_BITS;
	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_BITS      = 32;
	localparam int COEF_FRAC_BITS = 24;
	localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS;
	// five products plus rounding term: three guard bits
	localparam int ACC_BITS       = PROD_BITS + 3;
	localparam int SHIFT_BITS     = ACC_BITS - COEF_FRAC_BITS;
	localparam int CFG_IDX_BITS   = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FEED0,
		REG_FEED1,
		REG_FEED2,
		REG_BACK1,
		REG_BACK2,
		REG_PASS
	} cfg_reg_t;

	typedef enum logic {
		CMD_FILTER,
		CMD_CLEAR
	} cmd_t;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic signed [PROD_BITS-1:0]   prod_t;
	typedef logic signed [ACC_BITS-1:0]    acc_t;

	typedef struct packed {
		cmd_t               command;
		sample_t            sample_in;
		logic [CH_BITS-1:0] channel;
	} in_item_t;

	typedef struct packed {
		sample_t            sample_out;
		logic [CH_BITS-1:0] channel_out;
	} out_item_t;

	typedef struct packed {
		sample_t x1;
		sample_t x2;
		sample_t y1;
		sample_t y2;
	} hist_t;

endpackage

// ----- hw/rtl/multichannel_biquad_shelf_filter.sv -----
// Pipeline: accepted sample transactions pass through s1, s2, s3 and the output register.
// Throughput: one transaction per cycle across channels unless the output stalls; a
// sample whose channel has a filtered sample still in s1..s3 waits
// (history memory read at accept, write back from s3). A clear waits until s1..s3
// are empty. Reset clears control, coefficients to defaults and all history
// valid flags; the history memory itself is not cleared.
`include "multichannel_biquad_shelf_filter_assert.svh"
module multichannel_biquad_shelf_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_ready,
	input  mbsf_pkg::in_item_t                   sample_data,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output mbsf_pkg::out_item_t                  result_data,
	input  logic                                 cfg_we,
	input  logic [mbsf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [mbsf_pkg::COEF_BITS-1:0]       cfg_wdata
);
	import mbsf_pkg::*;

	localparam acc_t ROUND_TERM = acc_t'(1) <<< (COEF_FRAC_BITS - 1);
	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// configuration
	coef_t feed0_q, feed1_q, feed2_q, back1_q, back2_q;
	logic  pass_q;

	// history storage
	hist_t               hist_mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] hist_valid_q;

	// pipeline
	logic               v_s1, byp_s1;
	sample_t            x_s1;
	logic [CH_BITS-1:0] ch_s1;
	hist_t              rd_s1;

	logic               v_s2, byp_s2;
	sample_t            x_s2, x1_s2, y1_s2;
	logic [CH_BITS-1:0] ch_s2;
	prod_t              p0_s2, p1_s2, p2_s2, p3_s2, p4_s2;

	logic               v_s3, byp_s3;
	sample_t            x_s3, x1_s3, y1_s3;
	logic [CH_BITS-1:0] ch_s3;
	acc_t               sa_s3, sb_s3, sc_s3;

	logic      res_v_q;
	out_item_t res_q;

	logic en_out, en3, en2, en1;
	logic hazard, in_fire, clear_fire, item_fire, wb_en;
	logic s3_ch_hit;
	hist_t hist_sel;
	prod_t m0, m1, m2, m3, m4;
	acc_t  acc;
	logic signed [SHIFT_BITS-1:0] y_wide;
	logic  y_ovf;
	sample_t y_sat;

	// stall chain: a stage moves when the one after it is empty or moving
	assign en_out = !res_v_q || result_ready;
	assign en3    = !v_s3 || en_out;
	assign en2    = !v_s2 || en3;
	assign en1    = !v_s1 || en2;

	always_comb begin
		if (sample_data.command == CMD_CLEAR) begin
			hazard = v_s1 || v_s2 || v_s3;
		end else begin
			hazard = (v_s1 && !byp_s1 && ch_s1 == sample_data.channel) ||
				(v_s2 && !byp_s2 && ch_s2 == sample_data.channel) ||
				(v_s3 && !byp_s3 && ch_s3 == sample_data.channel);
		end
	end

	assign sample_ready = en1 && !hazard;
	assign in_fire      = sample_valid && sample_ready;
	assign clear_fire   = in_fire && sample_data.command == CMD_CLEAR;
	assign item_fire    = in_fire && sample_data.command == CMD_FILTER;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed0_q <= coef_t'(1) <<< COEF_FRAC_BITS;
			feed1_q <= '0;
			feed2_q <= '0;
			back1_q <= '0;
			back2_q <= '0;
			pass_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FEED0: feed0_q <= cfg_wdata;
				REG_FEED1: feed1_q <= cfg_wdata;
				REG_FEED2: feed2_q <= cfg_wdata;
				REG_BACK1: back1_q <= cfg_wdata;
				REG_BACK2: back2_q <= cfg_wdata;
				REG_PASS:  pass_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// history memory: read at accept, written back from s3
	always_ff @(posedge clk) begin
		if (item_fire) begin
			rd_s1 <= hist_mem[sample_data.channel];
		end
	end

	always_ff @(posedge clk) begin
		if (wb_en) begin
			hist_mem[ch_s3] <= '{x1: x_s3, x2: x1_s3, y1: y_sat, y2: y1_s3};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_valid_q <= '0;
		end else if (clear_fire) begin
			hist_valid_q <= '0;
		end else if (wb_en) begin
			hist_valid_q[ch_s3] <= 1'b1;
		end
	end

	// s1: select history, multiply
	assign hist_sel = hist_valid_q[ch_s1] ? rd_s1 : '0;
	assign m0 = prod_t'(feed0_q) * prod_t'(x_s1);
	assign m1 = prod_t'(feed1_q) * prod_t'(hist_sel.x1);
	assign m2 = prod_t'(feed2_q) * prod_t'(hist_sel.x2);
	assign m3 = prod_t'(back1_q) * prod_t'(hist_sel.y1);
	assign m4 = prod_t'(back2_q) * prod_t'(hist_sel.y2);

	// s3: final sum, round, floor shift, saturate
	assign acc    = sa_s3 + sb_s3 + sc_s3;
	assign y_wide = acc[ACC_BITS-1:COEF_FRAC_BITS];
	assign y_ovf  = !((&y_wide[SHIFT_BITS-1:SAMPLE_BITS-1]) ||
		!(|y_wide[SHIFT_BITS-1:SAMPLE_BITS-1]));
	assign y_sat  = y_ovf ? (y_wide[SHIFT_BITS-1] ? SAMPLE_MIN : SAMPLE_MAX)
		: y_wide[SAMPLE_BITS-1:0];
	assign wb_en  = v_s3 && !byp_s3 && en_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= item_fire;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en_out) begin
				res_v_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			byp_s1 <= pass_q;
			x_s1   <= sample_data.sample_in;
			ch_s1  <= sample_data.channel;
		end
		if (en2 && v_s1) begin
			byp_s2 <= byp_s1;
			x_s2   <= x_s1;
			x1_s2  <= hist_sel.x1;
			y1_s2  <= hist_sel.y1;
			ch_s2  <= ch_s1;
			p0_s2  <= m0;
			p1_s2  <= m1;
			p2_s2  <= m2;
			p3_s2  <= m3;
			p4_s2  <= m4;
		end
		if (en3 && v_s2) begin
			byp_s3 <= byp_s2;
			x_s3   <= x_s2;
			x1_s3  <= x1_s2;
			y1_s3  <= y1_s2;
			ch_s3  <= ch_s2;
			sa_s3  <= acc_t'(p0_s2) + acc_t'(p1_s2);
			sb_s3  <= acc_t'(p2_s2) + acc_t'(p3_s2);
			sc_s3  <= acc_t'(p4_s2) + ROUND_TERM;
		end
		if (en_out && v_s3) begin
			res_q.sample_out  <= byp_s3 ? x_s3 : y_sat;
			res_q.channel_out <= ch_s3;
		end
	end

	assign result_valid = res_v_q;
	assign result_data  = res_q;

	// filter transaction offered for the channel sitting in s3
	assign s3_ch_hit = v_s3 && !byp_s3 && sample_valid &&
		sample_data.command == CMD_FILTER && sample_data.channel == ch_s3;

	`MBSF_ASSERT_NEXT(a_clear_empties, clk, arst_n, clear_fire, hist_valid_q == '0)
	`MBSF_ASSERT_IMPL(a_same_ch_interlock, clk, arst_n, s3_ch_hit, !sample_ready)
	`MBSF_ASSERT_NEVER(a_wb_vs_clear, clk, arst_n, wb_en && clear_fire)

endmodule

// ----- tb/mbsf_result_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the multichannel biquad shelf filter: follows register writes
// and per-channel history, predicts each result and compares it. Depends on mbsf_pkg.
module mbsf_result_checker
	import mbsf_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sample_valid,
	input  logic                    sample_ready,
	input  in_item_t                sample_data,
	input  logic                    result_valid,
	input  logic                    result_ready,
	input  out_item_t               result_data,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COEF_BITS-1:0]    cfg_wdata,
	output int                      mismatch_count,
	output int                      outstanding
);

	localparam longint SAMPLE_HI  = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_LO  = -SAMPLE_HI - 1;
	localparam longint ROUND_HALF = longint'(1) << (COEF_FRAC_BITS - 1);
	localparam coef_t  UNITY_GAIN = coef_t'(longint'(1) << COEF_FRAC_BITS);

	coef_t     gain_ff0, gain_ff1, gain_ff2, gain_fb1, gain_fb2;
	logic      bypass;
	sample_t   x1_mem [NUM_CHANNELS];
	sample_t   x2_mem [NUM_CHANNELS];
	sample_t   y1_mem [NUM_CHANNELS];
	sample_t   y2_mem [NUM_CHANNELS];
	logic      hist_ok [NUM_CHANNELS];
	out_item_t expected_outputs [$];

	// One direct form I step on channel ch; shifts that channel's history.
	function automatic sample_t shelf_step(sample_t x, logic [CH_BITS-1:0] ch);
		longint  acc;
		sample_t px1, px2, py1, py2, y;
		if (hist_ok[ch]) begin
			px1 = x1_mem[ch];
			px2 = x2_mem[ch];
			py1 = y1_mem[ch];
			py2 = y2_mem[ch];
		end else begin
			px1 = '0;
			px2 = '0;
			py1 = '0;
			py2 = '0;
		end
		acc = longint'(gain_ff0) * longint'(x) + longint'(gain_ff1) * longint'(px1)
			+ longint'(gain_ff2) * longint'(px2) + longint'(gain_fb1) * longint'(py1)
			+ longint'(gain_fb2) * longint'(py2) + ROUND_HALF;
		acc = acc >>> COEF_FRAC_BITS;
		if (acc > SAMPLE_HI) begin
			y = sample_t'(SAMPLE_HI);
		end else if (acc < SAMPLE_LO) begin
			y = sample_t'(SAMPLE_LO);
		end else begin
			y = sample_t'(acc);
		end
		x2_mem[ch] = px1;
		x1_mem[ch] = x;
		y2_mem[ch] = py1;
		y1_mem[ch] = y;
		hist_ok[ch] = 1'b1;
		return y;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t got;
		out_item_t want;
		if (!arst_n) begin
			gain_ff0 = UNITY_GAIN;
			gain_ff1 = '0;
			gain_ff2 = '0;
			gain_fb1 = '0;
			gain_fb2 = '0;
			bypass   = 1'b0;
			foreach (hist_ok[i])
				hist_ok[i] = 1'b0;
			expected_outputs.delete();
			mismatch_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
				REG_FEED0: gain_ff0 = cfg_wdata;
				REG_FEED1: gain_ff1 = cfg_wdata;
				REG_FEED2: gain_ff2 = cfg_wdata;
				REG_BACK1: gain_fb1 = cfg_wdata;
				REG_BACK2: gain_fb2 = cfg_wdata;
				REG_PASS:  bypass   = cfg_wdata[0];
				default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				got = result_data;
				if (expected_outputs.size() == 0) begin
					$display("%0t: unexpected result: sample %0d channel %0d",
						$time, got.sample_out, got.channel_out);
					mismatch_count++;
				end else begin
					want = expected_outputs.pop_front();
					if (got.sample_out !== want.sample_out) begin
						$display("%0t: sample_out mismatch: expected %0d, got %0d",
							$time, want.sample_out, got.sample_out);
						mismatch_count++;
					end
					if (got.channel_out !== want.channel_out) begin
						$display("%0t: channel_out mismatch: expected %0d, got %0d",
							$time, want.channel_out, got.channel_out);
						mismatch_count++;
					end
				end
			end
			if (sample_valid && sample_ready) begin
				if (sample_data.command == CMD_CLEAR) begin
					// clear drops all history, bypass or not; no result
					foreach (hist_ok[i])
						hist_ok[i] = 1'b0;
				end else begin
					want.channel_out = sample_data.channel;
					if (bypass)
						want.sample_out = sample_data.sample_in;
					else
						want.sample_out = shelf_step(sample_data.sample_in, sample_data.channel);
					expected_outputs.push_back(want);
				end
			end
		end
		outstanding = expected_outputs.size();
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Top of the multichannel biquad shelf filter testbench: clock, reset, stimulus
// and verdict. Depends on mbsf_pkg, the filter RTL and mbsf_result_checker.
module tb;
	import mbsf_pkg::*;

	localparam int      LATENCY     = 4;
	localparam int      PHASES      = 12;
	localparam int      PHASE_ITEMS = 85;
	localparam int      CYCLE_LIMIT = 400000;
	localparam coef_t   COEF_MAX    = 32'sh7fff_ffff;
	localparam coef_t   COEF_MIN    = 32'sh8000_0000;
	localparam coef_t   COEF_ONE    = 32'sh0100_0000;
	localparam sample_t FULL_POS    = 24'sh7f_ffff;
	localparam sample_t FULL_NEG    = 24'sh80_0000;

	logic                    clk;
	logic                    arst_n;
	logic                    sample_valid;
	logic                    sample_ready;
	in_item_t                sample_data;
	logic                    result_valid;
	logic                    result_ready = 1'b0;
	out_item_t               result_data;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [COEF_BITS-1:0]    cfg_wdata;
	int                      mismatch_count;
	int                      outstanding;
	int                      cycle_count = 0;
	int                      sender_idle_pct = 0;
	int                      receiver_stall_pct = 0;
	logic [CH_BITS-1:0]      last_channel = '0;

	multichannel_biquad_shelf_filter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_data  (sample_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	mbsf_result_checker result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.sample_data    (sample_data),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.result_data    (result_data),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin
		result_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic in_item_t filter_item(sample_t s, logic [CH_BITS-1:0] ch);
		in_item_t item;
		item.command   = CMD_FILTER;
		item.sample_in = s;
		item.channel   = ch;
		return item;
	endfunction

	function automatic in_item_t clear_item();
		in_item_t item;
		item.command   = CMD_CLEAR;
		item.sample_in = sample_t'($urandom);
		item.channel   = CH_BITS'($urandom_range(NUM_CHANNELS - 1));
		return item;
	endfunction

	function automatic sample_t random_sample();
		case ($urandom_range(9))
		0: return FULL_POS;
		1: return FULL_NEG;
		2: return $urandom_range(1) ? sample_t'(0) : sample_t'(-1);
		default: return sample_t'($urandom);
		endcase
	endfunction

	// Mostly filter transactions; repeats a channel often to hit the interlock.
	function in_item_t random_item();
		if ($urandom_range(99) < 3)
			return clear_item();
		if ($urandom_range(99) >= 30)
			last_channel = CH_BITS'($urandom_range(NUM_CHANNELS - 1));
		return filter_item(random_sample(), last_channel);
	endfunction

	function automatic coef_t gentle_coef();
		return coef_t'($signed($urandom) >>> 6);
	endfunction

	function automatic coef_t corner_coef();
		case ($urandom_range(4))
		0: return COEF_MAX;
		1: return COEF_MIN;
		2: return '0;
		3: return COEF_ONE;
		default: return coef_t'($urandom);
		endcase
	endfunction

	task automatic send_item(in_item_t item);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample_data  <= item;
		do
			@(posedge clk);
		while (!sample_ready);
	endtask

	// Stop sending, wait for every pending result, then let a clear settle.
	task automatic drain_results();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (2 * LATENCY) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [COEF_BITS-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_coefs(coef_t f0, coef_t f1, coef_t f2, coef_t b1, coef_t b2,
		logic pass);
		drain_results();
		write_reg(REG_FEED0, f0);
		write_reg(REG_FEED1, f1);
		write_reg(REG_FEED2, f2);
		write_reg(REG_BACK1, b1);
		write_reg(REG_BACK2, b2);
		write_reg(REG_PASS, {31'($urandom) << 1, pass});
	endtask

	initial begin
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample_data  = '0;
		cfg_we       = 1'b0;
		cfg_index    = REG_FEED0;
		cfg_wdata    = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// unity gain out of reset
		send_item(filter_item(FULL_POS, 4'd0));
		send_item(filter_item(FULL_NEG, 4'd15));
		send_item(filter_item(sample_t'(0), 4'd5));
		send_item(filter_item(sample_t'(-1), 4'd5));
		send_item(clear_item());
		send_item(filter_item(sample_t'(1), 4'd0));

		// full-scale coefficients, sums clamp both ways
		set_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 1'b0);
		send_item(filter_item(FULL_POS, 4'd0));
		send_item(filter_item(FULL_NEG, 4'd0));
		send_item(filter_item(FULL_POS, 4'd0));
		send_item(filter_item(sample_t'(-1), 4'd3));
		send_item(filter_item(sample_t'(1), 4'd3));

		// bypass, with a clear that must still drop history
		set_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 1'b1);
		send_item(filter_item(FULL_NEG, 4'd15));
		send_item(clear_item());
		send_item(filter_item(FULL_POS, 4'd7));

		set_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 1'b0);
		send_item(filter_item(FULL_POS, 4'd0));
		send_item(filter_item(FULL_NEG, 4'd0));
		send_item(filter_item(FULL_POS, 4'd0));
		send_item(filter_item(sample_t'(-1), 4'd9));

		for (int p = 0; p < PHASES; p++) begin
			case (p % 6)
			0: set_coefs(gentle_coef(), gentle_coef(), gentle_coef(),
				gentle_coef(), gentle_coef(), 1'b0);
			1: set_coefs(coef_t'($urandom), coef_t'($urandom), coef_t'($urandom),
				coef_t'($urandom), coef_t'($urandom), 1'b0);
			2: set_coefs(gentle_coef(), gentle_coef(), gentle_coef(),
				gentle_coef(), gentle_coef(), 1'b1);
			// stable shelf: complex pole pair of radius about 0.67
			3: set_coefs(32'sd25165824, -32'sd20132659, 32'sd6710886,
				32'sd21810380, -32'sd7549747, 1'b0);
			default: set_coefs(corner_coef(), corner_coef(), corner_coef(),
				corner_coef(), corner_coef(), 1'b0);
			endcase
			case (p % 4)
			0: begin
				sender_idle_pct    = 0;
				receiver_stall_pct = 0;
			end
			1: begin
				sender_idle_pct    = 79;
				receiver_stall_pct = 0;
			end
			2: begin
				sender_idle_pct    = 0;
				receiver_stall_pct = 79;
			end
			default: begin
				sender_idle_pct    = 19;
				receiver_stall_pct = 19;
			end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p % 3 == 1 && n == PHASE_ITEMS / 2)
					drain_results();
				send_item(random_item());
			end
		end

		drain_results();
		repeat (4 * LATENCY) @(negedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
